@@ rtl/life_cellular_automaton_engine_top_defines.svh @@
// Assertion macros shared by the life engine RTL.
`ifndef LIFE_CELLULAR_AUTOMATON_ENGINE_TOP_DEFINES_SVH
`define LIFE_CELLULAR_AUTOMATON_ENGINE_TOP_DEFINES_SVH

// Plain property, sampled on clk_i, off while rst_ni is low.
`define LCAE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LCAE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/lcae_pkg.sv @@
// Shared constants, types and pixel mapping for the life engine.
package lcae_pkg;

  localparam int unsigned GRID_W      = 64;
  localparam int unsigned GRID_H      = 64;
  localparam int unsigned VIEW_PIXELS = 800;

  localparam int unsigned PIX_W   = 10;
  localparam int unsigned COL_W   = $clog2(GRID_W);
  localparam int unsigned ROW_W   = $clog2(GRID_H);
  localparam int unsigned ADDR_W  = ROW_W + 1;          // bank bit on top of the row
  localparam int unsigned STEP_W  = $clog2(GRID_H + 2);
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned DIV_RST = 100;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_RUNNING  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DIV = 1'd1;

  // pixels per cell, at least one
  localparam int unsigned SPAN_X = (VIEW_PIXELS / GRID_W == 0) ? 1 : VIEW_PIXELS / GRID_W;
  localparam int unsigned SPAN_Y = (VIEW_PIXELS / GRID_H == 0) ? 1 : VIEW_PIXELS / GRID_H;

  // ceil(2^RECIP_SH / span): exact floor division for any 10-bit pixel
  localparam int unsigned RECIP_SH = 32;
  localparam logic [RECIP_SH:0] RECIP_X =
    (RECIP_SH+1)'(((64'd1 << RECIP_SH) + 64'(SPAN_X) - 64'd1) / 64'(SPAN_X));
  localparam logic [RECIP_SH:0] RECIP_Y =
    (RECIP_SH+1)'(((64'd1 << RECIP_SH) + 64'(SPAN_Y) - 64'd1) / 64'(SPAN_Y));

  typedef enum logic [1:0] {
    ACT_PAINT_ALIVE = 2'd0,
    ACT_PAINT_DEAD  = 2'd1,
    ACT_TICK        = 2'd2,
    ACT_READ        = 2'd3
  } action_e;

  // one read and one write port of the grid store
  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [GRID_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic rem_zero;
  } mod_stat_t;

  // pixel / span by reciprocal multiply, clamped to the last cell
  function automatic logic [PIX_W:0] px_to_idx(input logic [PIX_W-1:0]  pix,
                                               input logic [RECIP_SH:0] recip,
                                               input logic [PIX_W:0]    last);
    logic [PIX_W+RECIP_SH:0] prod;
    logic [PIX_W:0]          q;
    prod = (PIX_W+RECIP_SH+1)'(pix) * (PIX_W+RECIP_SH+1)'(recip);
    q    = prod[PIX_W+RECIP_SH:RECIP_SH];
    return (q > last) ? last : q;
  endfunction

  function automatic logic [COL_W-1:0] px_to_col(input logic [PIX_W-1:0] pix);
    logic [PIX_W:0] idx;
    idx = px_to_idx(pix, RECIP_X, (PIX_W+1)'(GRID_W - 1));
    return idx[COL_W-1:0];
  endfunction

  function automatic logic [ROW_W-1:0] px_to_row(input logic [PIX_W-1:0] pix);
    logic [PIX_W:0] idx;
    idx = px_to_idx(pix, RECIP_Y, (PIX_W+1)'(GRID_H - 1));
    return idx[ROW_W-1:0];
  endfunction

endpackage

@@ rtl/lcae_if.sv @@
// Valid/ready channel interfaces: action input, result output, register writes.
interface lcae_in_if import lcae_pkg::*;;
  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;

  modport source (output valid, action, pixel_x, pixel_y, input ready);
  modport sink   (input valid, action, pixel_x, pixel_y, output ready);
endinterface

interface lcae_out_if;
  logic valid;
  logic ready;
  logic cell_alive;
  logic generation_ran;

  modport source (output valid, cell_alive, generation_ran, input ready);
  modport sink   (input valid, cell_alive, generation_ran, output ready);
endinterface

interface lcae_cfg_if import lcae_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/lcae_grid_mem.sv @@
// Row-wide grid store: two banks of GRID_H rows, one read and one write port.
module lcae_grid_mem import lcae_pkg::*; (
  input  logic              clk_i,
  input  mem_req_t          req_i,
  output logic [GRID_W-1:0] rdata_o
);

  logic [GRID_W-1:0] mem_q [2**ADDR_W];
  logic [GRID_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/lcae_row_rule.sv @@
// B3/S23 update of one full row from the rows above, at and below it.
module lcae_row_rule import lcae_pkg::*; (
  input  logic [GRID_W-1:0] up_i,
  input  logic [GRID_W-1:0] mid_i,
  input  logic [GRID_W-1:0] dn_i,
  output logic [GRID_W-1:0] row_o
);

  // dead column either side of the grid
  logic [GRID_W+1:0] up_p, mid_p, dn_p;

  assign up_p  = {1'b0, up_i, 1'b0};
  assign mid_p = {1'b0, mid_i, 1'b0};
  assign dn_p  = {1'b0, dn_i, 1'b0};

  for (genvar c = 0; c < GRID_W; c++) begin : g_col
    logic [3:0] n;
    assign n = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2])
             + 4'(mid_p[c]) + 4'(mid_p[c+2])
             + 4'(dn_p[c]) + 4'(dn_p[c+1]) + 4'(dn_p[c+2]);
    assign row_o[c] = (n == 4'd3) || ((n == 4'd2) && mid_i[c]);
  end

endmodule

@@ rtl/lcae_mod_unit.sv @@
// Bit-serial remainder unit: tick counter modulo step divisor, one bit a cycle.
`include "life_cellular_automaton_engine_top_defines.svh"
module lcae_mod_unit import lcae_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CNT_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output mod_stat_t        stat_o
);

  localparam int unsigned BIT_W = $clog2(CNT_W);

  logic             busy_q, done_q;
  logic [BIT_W-1:0] bit_q;
  logic [CNT_W-1:0] num_q, rem_q, div_q;
  logic [CNT_W:0]   shifted;
  logic [CNT_W-1:0] rem_d;

  always_comb begin
    shifted = {rem_q, num_q[CNT_W-1]};
    if (shifted >= {1'b0, div_q}) begin
      rem_d = CNT_W'(shifted - {1'b0, div_q});
    end else begin
      rem_d = CNT_W'(shifted);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else if (busy_q) begin
      bit_q <= bit_q + BIT_W'(1);
      if (bit_q == BIT_W'(CNT_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      div_q <= (divisor_i == '0) ? CNT_W'(1) : divisor_i;  // zero acts as one
    end else if (busy_q) begin
      num_q <= {num_q[CNT_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy     = busy_q;
  assign stat_o.done     = done_q;
  assign stat_o.rem_zero = (rem_q == '0);

  `LCAE_ASSERT_IMP(a_rem_below_div, busy_q, rem_q < div_q, "remainder reached divisor")
  `LCAE_ASSERT_IMP(a_done_after_busy, done_q, !busy_q && $past(busy_q), "done without a run")

endmodule

@@ rtl/life_cellular_automaton_engine_top.sv @@
// Top level of the B3/S23 life engine: control sequencer around the grid store.
// Usage
//   in_i  : one transaction per action (paint alive, paint dead, tick, read cell)
//           with a pixel position; paint and read clamp it to the last row/column.
//   out_o : exactly one result transaction per action: cell_alive for paint/read,
//           generation_ran for a tick that ran a generation.
//   cfg_i : register writes (running, step_divisor); always ready, to be used only
//           while the engine is idle.
// Sequence (from acceptance to the result in the output register)
//   Paint/read: one row read, then for paint a write of that row with the cell set.
//   Tick without generation: waits on the 16-step bit-serial modulo unit.
//   Tick with generation: the modulo unit, then one row read per cycle, the
//   whole row updated at once into the other bank, then banks swap.
// Reset
//   After rst_ni the engine clears all GRID_H rows of bank 0 to dead
//   before in_i goes ready; cfg_i writes are taken throughout.
// Back-pressure
//   The result waits in the output register while out_o.ready is low; the next
//   action may be accepted and worked on meanwhile, its result held until the
//   register frees.
`include "life_cellular_automaton_engine_top_defines.svh"
module life_cellular_automaton_engine_top import lcae_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  lcae_in_if.sink    in_i,
  lcae_out_if.source out_o,
  lcae_cfg_if.sink   cfg_i
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CELL  = 3'd2;
  localparam logic [2:0] ST_MOD   = 3'd3;
  localparam logic [2:0] ST_GEN   = 3'd4;
  localparam logic [2:0] ST_RESP  = 3'd5;

  localparam logic [STEP_W-1:0] GEN_LAST = STEP_W'(GRID_H + 1);

  // control state
  logic [2:0]       state_q, state_d;
  logic [ROW_W-1:0] clr_row_q, clr_row_d;
  logic             sel_q, sel_d;              // bank holding the live grid
  logic             running_q, running_d;
  logic [CNT_W-1:0] step_div_q, step_div_d;
  logic [CNT_W-1:0] tick_count_q, tick_count_d;
  logic [STEP_W-1:0] gen_step_q, gen_step_d;
  logic             out_valid_q, out_valid_d;

  // payload
  action_e           act_q, act_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [GRID_W-1:0] up_q, up_d, mid_q, mid_d;
  logic              res_alive_q, res_alive_d, res_ran_q, res_ran_d;
  logic              out_alive_q, out_alive_d, out_ran_q, out_ran_d;

  // datapath
  mem_req_t          mem_req;
  logic [GRID_W-1:0] rd_data, below, new_row, row_mod;
  logic              mod_start;
  mod_stat_t         mod_stat;
  logic              in_acc;
  action_e           in_act;
  logic [COL_W-1:0]  in_col;
  logic [ROW_W-1:0]  in_row;
  logic              cell_new;
  logic              out_load;

  lcae_grid_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rd_data)
  );

  lcae_row_rule u_rule (
    .up_i  (up_q),
    .mid_i (mid_q),
    .dn_i  (below),
    .row_o (new_row)
  );

  lcae_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (tick_count_q),
    .divisor_i  (step_div_q),
    .stat_o     (mod_stat)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;
  assign in_act      = action_e'(in_i.action);
  assign in_col      = px_to_col(in_i.pixel_x);
  assign in_row      = px_to_row(in_i.pixel_y);

  // row below the one being updated: read data during the scan, dead past the grid
  assign below = ((gen_step_q >= STEP_W'(1)) && (gen_step_q <= STEP_W'(GRID_H)))
               ? rd_data : '0;

  always_comb begin
    cell_new = rd_data[col_q];
    case (act_q)
      ACT_PAINT_ALIVE: cell_new = 1'b1;
      ACT_PAINT_DEAD:  cell_new = 1'b0;
      default:         cell_new = rd_data[col_q];
    endcase
    row_mod         = rd_data;
    row_mod[col_q]  = cell_new;
  end

  always_comb begin
    state_d      = state_q;
    clr_row_d    = clr_row_q;
    sel_d        = sel_q;
    running_d    = running_q;
    step_div_d   = step_div_q;
    tick_count_d = tick_count_q;
    gen_step_d   = gen_step_q;
    act_d        = act_q;
    col_d        = col_q;
    row_d        = row_q;
    up_d         = up_q;
    mid_d        = mid_q;
    res_alive_d  = res_alive_q;
    res_ran_d    = res_ran_q;
    mem_req      = '0;
    mod_start    = 1'b0;
    out_load     = 1'b0;

    if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        REG_RUNNING:  running_d  = cfg_i.data[0];
        REG_STEP_DIV: step_div_d = cfg_i.data;
        default: ;
      endcase
    end

    case (state_q)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = {1'b0, clr_row_q};
        mem_req.wdata = '0;
        clr_row_d     = clr_row_q + ROW_W'(1);
        if (clr_row_q == ROW_W'(GRID_H - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          act_d = in_act;
          col_d = in_col;
          row_d = in_row;
          if (in_act == ACT_TICK) begin
            mod_start    = 1'b1;             // divides the pre-increment count
            tick_count_d = tick_count_q + CNT_W'(1);
            state_d      = ST_MOD;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = {sel_q, in_row};
            state_d       = ST_CELL;
          end
        end
      end
      ST_CELL: begin
        if (act_q inside {ACT_PAINT_ALIVE, ACT_PAINT_DEAD}) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = {sel_q, row_q};
          mem_req.wdata = row_mod;
        end
        res_alive_d = cell_new;
        res_ran_d   = 1'b0;
        state_d     = ST_RESP;
      end
      ST_MOD: begin
        if (mod_stat.done) begin
          if (running_q && mod_stat.rem_zero) begin
            gen_step_d = '0;
            up_d       = '0;
            mid_d      = '0;
            state_d    = ST_GEN;
          end else begin
            res_alive_d = 1'b0;
            res_ran_d   = 1'b0;
            state_d     = ST_RESP;
          end
        end
      end
      ST_GEN: begin
        // step s: read row s, row s-1 arrives, row s-2 is written to the spare bank
        if (gen_step_q < STEP_W'(GRID_H)) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = {sel_q, gen_step_q[ROW_W-1:0]};
        end
        if (gen_step_q >= STEP_W'(2)) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = {~sel_q, ROW_W'(gen_step_q - STEP_W'(2))};
          mem_req.wdata = new_row;
        end
        if (gen_step_q >= STEP_W'(1)) begin
          up_d  = mid_q;
          mid_d = below;
        end
        if (gen_step_q == GEN_LAST) begin
          sel_d       = ~sel_q;
          res_alive_d = 1'b0;
          res_ran_d   = 1'b1;
          state_d     = ST_RESP;
        end else begin
          gen_step_d = gen_step_q + STEP_W'(1);
        end
      end
      ST_RESP: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_alive_d = out_alive_q;
    out_ran_d   = out_ran_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_alive_d = res_alive_q;
      out_ran_d   = res_ran_q;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_row_q    <= '0;
      sel_q        <= 1'b0;
      running_q    <= 1'b0;
      step_div_q   <= CNT_W'(DIV_RST);
      tick_count_q <= '0;
      gen_step_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_row_q    <= clr_row_d;
      sel_q        <= sel_d;
      running_q    <= running_d;
      step_div_q   <= step_div_d;
      tick_count_q <= tick_count_d;
      gen_step_q   <= gen_step_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    col_q       <= col_d;
    row_q       <= row_d;
    up_q        <= up_d;
    mid_q       <= mid_d;
    res_alive_q <= res_alive_d;
    res_ran_q   <= res_ran_d;
    out_alive_q <= out_alive_d;
    out_ran_q   <= out_ran_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.cell_alive     = out_alive_q;
  assign out_o.generation_ran = out_ran_q;

  `LCAE_ASSERT_IMP(a_gen_spare_bank, (state_q == ST_GEN) && mem_req.we,
                   mem_req.waddr[ROW_W] != sel_q, "generation wrote the live bank")
  `LCAE_ASSERT_IMP(a_gen_step_range, state_q == ST_GEN, gen_step_q <= GEN_LAST,
                   "generation step out of range")
  `LCAE_ASSERT_IMP(a_mod_in_flight, state_q == ST_MOD, mod_stat.busy || mod_stat.done,
                   "modulo unit idle while a tick waits")

endmodule
